/* rtl/lgd_pkg.sv */
// Shared constants, types and functions of the lattice Gaussian density block.
// Holds the exp table builder, the divide-by-five helper and signed saturation.
`timescale 1ns / 1ps
package lgd_pkg;

    localparam int WINDOW_RADIUS  = 5;
    localparam int EXP_TABLE_SIZE = 256;

    localparam int NUM_REGS = 8;
    localparam int ADDR_W   = 3;
    localparam int REG_W    = 64;
    localparam int Q_W      = 32;
    localparam int POS_W    = 52;
    localparam int ACC_W    = 66;
    localparam int CNT_W    = $clog2(2 * WINDOW_RADIUS + 3);
    localparam int STEP_W   = 5;

    localparam int CUT_SHIFT = 18;
    localparam int CUTOFF    = 5 << CUT_SHIFT;
    localparam int T_W       = $clog2(CUTOFF);
    localparam int IDX_W     = $clog2(EXP_TABLE_SIZE + 1);
    localparam int P_W       = T_W + IDX_W;
    localparam int E_W       = 17;
    localparam int M_W       = E_W + T_W;
    localparam int SUM_W     = $clog2(2 * (2 * WINDOW_RADIUS + 2) * (2 * WINDOW_RADIUS + 2)
                                      * 65536 + 1);
    localparam int DIV_IN_W  = 22;
    localparam logic [25:0] DIV5_RECIP = 26'((64'd1 << 26) / 5);
    localparam logic [63:0] EXP_STEP_X = (64'd20 << 30) / 64'(EXP_TABLE_SIZE);

    localparam logic [ADDR_W-1:0] REG_V1     = 3'd0;
    localparam logic [ADDR_W-1:0] REG_V2     = 3'd1;
    localparam logic [ADDR_W-1:0] REG_BASIS  = 3'd2;
    localparam logic [ADDR_W-1:0] REG_CENTER = 3'd3;
    localparam logic [ADDR_W-1:0] REG_ROT    = 3'd4;
    localparam logic [ADDR_W-1:0] REG_INV1   = 3'd5;
    localparam logic [ADDR_W-1:0] REG_INV2   = 3'd6;
    localparam logic [ADDR_W-1:0] REG_ALPHA  = 3'd7;
    localparam logic [REG_W-1:0]  ROT_RESET  = 64'h0000_0001_0000_0000;

    // setup sequence steps
    localparam logic [STEP_W-1:0] ST_DIFF  = 5'd0;
    localparam logic [STEP_W-1:0] ST_R1    = 5'd1;
    localparam logic [STEP_W-1:0] ST_R2    = 5'd2;
    localparam logic [STEP_W-1:0] ST_R3    = 5'd3;
    localparam logic [STEP_W-1:0] ST_R4    = 5'd4;
    localparam logic [STEP_W-1:0] ST_R5    = 5'd5;
    localparam logic [STEP_W-1:0] ST_DY    = 5'd6;
    localparam logic [STEP_W-1:0] ST_I1    = 5'd7;
    localparam logic [STEP_W-1:0] ST_I2    = 5'd8;
    localparam logic [STEP_W-1:0] ST_I3    = 5'd9;
    localparam logic [STEP_W-1:0] ST_I4    = 5'd10;
    localparam logic [STEP_W-1:0] ST_I5    = 5'd11;
    localparam logic [STEP_W-1:0] ST_C2    = 5'd12;
    localparam logic [STEP_W-1:0] ST_P1    = 5'd13;
    localparam logic [STEP_W-1:0] ST_P2    = 5'd14;
    localparam logic [STEP_W-1:0] ST_P3    = 5'd15;
    localparam logic [STEP_W-1:0] ST_P4    = 5'd16;
    localparam logic [STEP_W-1:0] ST_P5    = 5'd17;
    localparam logic [STEP_W-1:0] ST_LAST  = 5'd18;

    typedef logic [EXP_TABLE_SIZE:0][E_W-1:0] t_exp_tab;

    typedef struct packed {
        logic              load;
        logic              setup;
        logic [STEP_W-1:0] step;
        logic              clear_sum;
        logic              issue;
        logic              atom;
        logic              step_col;
        logic              step_row;
        logic              scale;
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        logic             term_busy;
        logic             out_busy;
        logic [CNT_W-1:0] row_count;
        logic [CNT_W-1:0] col_count;
    } t_sts;

    // shift-subtract quotient, used only while the table is elaborated
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_exp_tab build_exp_tab();
        t_exp_tab    tab;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] f;
        x    = EXP_STEP_X;
        term = 64'd1 << 30;
        pos  = term;
        neg  = 64'd0;
        for (int k = 1; k <= 24; k++) begin
            term = udiv64(term * x, 64'(k) << 30);
            if ((k & 1) != 0) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        f    = (pos > neg) ? pos - neg : 64'd0;
        term = 64'd1 << 30;
        for (int k = 0; k <= EXP_TABLE_SIZE; k++) begin
            tab[k] = E_W'((term + (64'd1 << 13)) >> 14);
            term   = (term * f + (64'd1 << 29)) >> 30;
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp_tab();

    // reciprocal multiply with one correction step
    function automatic logic [DIV_IN_W-1:0] div5(input logic [DIV_IN_W-1:0] y);
        logic [DIV_IN_W+25:0] pr;
        logic [DIV_IN_W-1:0]  q;
        logic [DIV_IN_W-1:0]  r;
        pr = (DIV_IN_W + 26)'(y) * (DIV_IN_W + 26)'(DIV5_RECIP);
        q  = pr[DIV_IN_W+25:26];
        r  = y - DIV_IN_W'(q * 3'd5);
        if (r >= DIV_IN_W'(5)) begin
            q = q + 1'b1;
        end
        return q;
    endfunction

    function automatic logic signed [Q_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [Q_W-1:0] res;
        if (v > 66'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = Q_W'(v);
        end
        return res;
    endfunction

endpackage

/* rtl/lgd_ctrl.sv */
// Sequencer of the density block: setup steps, cell sweep, drain and output.
// Depends on lgd_pkg for the command and status types.
`timescale 1ns / 1ps
module lgd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  lgd_pkg::t_sts i_sts,
    output lgd_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_SETUP, S_TERMS, S_DRAIN, S_SCALE, S_FINISH
    } t_state;

    t_state                      r_state;
    logic [lgd_pkg::STEP_W-1:0]  r_step;
    logic [lgd_pkg::CNT_W-1:0]   r_row;
    logic [lgd_pkg::CNT_W-1:0]   r_col;
    logic                        r_atom;
    logic                        last_col;
    logic                        last_row;

    assign o_ready  = (r_state == S_IDLE);
    assign last_col = (r_col == i_sts.col_count - 1'b1);
    assign last_row = (r_row == i_sts.row_count - 1'b1);

    always_comb begin
        o_cmd           = '0;
        o_cmd.step      = r_step;
        o_cmd.atom      = r_atom;
        o_cmd.load      = o_ready && i_valid;
        o_cmd.clear_sum = o_ready && i_valid;
        o_cmd.setup     = (r_state == S_SETUP);
        o_cmd.issue     = (r_state == S_TERMS);
        o_cmd.step_col  = (r_state == S_TERMS) && r_atom && !last_col;
        o_cmd.step_row  = (r_state == S_TERMS) && r_atom && last_col;
        o_cmd.scale     = (r_state == S_SCALE);
        o_cmd.out_load  = (r_state == S_FINISH) && !i_sts.out_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_atom  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    if (i_valid) begin
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == lgd_pkg::ST_LAST) begin
                        r_state <= S_TERMS;
                        r_row   <= '0;
                        r_col   <= '0;
                        r_atom  <= 1'b0;
                    end
                end
                S_TERMS: begin
                    r_atom <= !r_atom;
                    if (r_atom) begin
                        if (last_col) begin
                            r_col <= '0;
                            r_row <= r_row + 1'b1;
                            if (last_row) begin
                                r_state <= S_DRAIN;
                            end
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                S_DRAIN: begin
                    if (!i_sts.term_busy) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (!i_sts.out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/lgd_term.sv */
// Gaussian term pipeline: distance, squared radius, table exp and running sum.
// One term enters per cycle. Depends on lgd_pkg for the exp table and helpers.
`timescale 1ns / 1ps
module lgd_term (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_clear,
    input  logic                                i_issue,
    input  logic signed [lgd_pkg::Q_W-1:0]      i_dx,
    input  logic signed [lgd_pkg::Q_W-1:0]      i_dy,
    input  logic signed [lgd_pkg::POS_W-1:0]    i_xa,
    input  logic signed [lgd_pkg::POS_W-1:0]    i_ya,
    input  logic signed [lgd_pkg::Q_W-1:0]      i_offx,
    input  logic signed [lgd_pkg::Q_W-1:0]      i_offy,
    input  logic [lgd_pkg::Q_W-1:0]             i_alpha,
    output logic [lgd_pkg::SUM_W-1:0]           o_sum,
    output logic                                o_busy
);

    logic [7:0]                        r_v;
    logic [7:3]                        r_hit;
    logic signed [lgd_pkg::Q_W-1:0]    r_ex, r_ey;
    logic [63:0]                       r_sqx, r_sqy;
    logic [lgd_pkg::Q_W-1:0]           r_r2;
    logic [lgd_pkg::T_W-1:0]           r_t;
    logic [lgd_pkg::P_W-1:0]           r_p;
    logic [lgd_pkg::IDX_W-1:0]         r_i;
    logic [lgd_pkg::T_W-1:0]           r_fr;
    logic [lgd_pkg::E_W-1:0]           r_a5, r_d5, r_a6, r_val;
    logic [lgd_pkg::M_W-1:0]           r_m;
    logic [lgd_pkg::SUM_W-1:0]         r_sum;

    logic [63:0]                       sq_sum;
    logic [63:0]                       apr;
    logic [lgd_pkg::P_W-1:0]           p;
    logic [lgd_pkg::DIV_IN_W-1:0]      idx_q;
    logic [lgd_pkg::DIV_IN_W-1:0]      lerp_q;

    assign sq_sum = r_sqx + r_sqy;
    assign apr    = 64'(i_alpha) * 64'(r_r2);
    assign p      = lgd_pkg::P_W'(r_t) * lgd_pkg::P_W'(lgd_pkg::EXP_TABLE_SIZE);
    assign idx_q  = lgd_pkg::div5(lgd_pkg::DIV_IN_W'(p >> lgd_pkg::CUT_SHIFT));
    assign lerp_q = lgd_pkg::div5(lgd_pkg::DIV_IN_W'(r_m >> lgd_pkg::CUT_SHIFT));

    assign o_sum  = r_sum;
    assign o_busy = |r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= '0;
            r_hit <= '0;
        end else begin
            r_v   <= {r_v[6:0], i_issue};
            r_hit <= {r_hit[6:3], (apr[63:16] < 48'(lgd_pkg::CUTOFF))};
        end
    end

    always_ff @(posedge i_clk) begin
        r_ex  <= lgd_pkg::sat32(lgd_pkg::ACC_W'(i_dx) - lgd_pkg::ACC_W'(i_xa)
                                - lgd_pkg::ACC_W'(i_offx));
        r_ey  <= lgd_pkg::sat32(lgd_pkg::ACC_W'(i_dy) - lgd_pkg::ACC_W'(i_ya)
                                - lgd_pkg::ACC_W'(i_offy));
        r_sqx <= 64'(64'(r_ex) * 64'(r_ex));
        r_sqy <= 64'(64'(r_ey) * 64'(r_ey));
        r_r2  <= (|sq_sum[63:48]) ? '1 : sq_sum[47:16];
        r_t   <= apr[16+lgd_pkg::T_W-1:16];
        r_p   <= p;
        r_i   <= lgd_pkg::IDX_W'(idx_q);
        r_fr  <= lgd_pkg::T_W'(r_p - lgd_pkg::P_W'(r_i) * lgd_pkg::P_W'(lgd_pkg::CUTOFF));
        r_a5  <= lgd_pkg::EXP_TAB[r_i];
        r_d5  <= lgd_pkg::EXP_TAB[r_i] - lgd_pkg::EXP_TAB[r_i + 1'b1];
        r_m   <= lgd_pkg::M_W'(r_d5) * lgd_pkg::M_W'(r_fr);
        r_a6  <= r_a5;
        r_val <= r_hit[6] ? r_a6 - lgd_pkg::E_W'(lerp_q) : '0;
        if (i_clear) begin
            r_sum <= '0;
        end else if (r_v[7] && r_hit[7]) begin
            r_sum <= r_sum + lgd_pkg::SUM_W'(r_val);
        end
    end

endmodule

/* rtl/lgd_datapath.sv */
// Datapath: configuration registers, setup multiplier, cell position walk,
// term pipeline and output register. Depends on lgd_pkg and lgd_term.
`timescale 1ns / 1ps
module lgd_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lgd_pkg::ADDR_W-1:0]          i_cfg_addr,
    input  logic [lgd_pkg::REG_W-1:0]           i_cfg_data,
    input  logic signed [lgd_pkg::Q_W-1:0]      i_point_x,
    input  logic signed [lgd_pkg::Q_W-1:0]      i_point_y,
    input  logic                                i_ready,
    output logic                                o_valid,
    output logic [lgd_pkg::Q_W-1:0]             o_density,
    input  lgd_pkg::t_cmd                       i_cmd,
    output lgd_pkg::t_sts                       o_sts
);

    localparam int DP_W = lgd_pkg::SUM_W + lgd_pkg::Q_W;

    logic [lgd_pkg::REG_W-1:0]          r_cfg [lgd_pkg::NUM_REGS];
    logic signed [lgd_pkg::Q_W-1:0]     r_px, r_py, r_rx, r_ry, r_dx, r_dy, r_c1, r_c2;
    logic signed [63:0]                 r_prod;
    logic signed [lgd_pkg::ACC_W-1:0]   r_acc;
    logic signed [lgd_pkg::POS_W-1:0]   r_xa, r_ya, r_xrow, r_yrow;
    logic [DP_W-1:0]                    r_dprod;
    logic                               r_out_valid;
    logic [lgd_pkg::Q_W-1:0]            r_density;

    logic signed [lgd_pkg::Q_W-1:0]     v1x, v1y, v2x, v2y, bx, by, cx, cy;
    logic signed [lgd_pkg::Q_W-1:0]     ct, st, i11, i12, i21, i22;
    logic [lgd_pkg::Q_W-1:0]            alpha, anorm;
    logic signed [lgd_pkg::Q_W-1:0]     lo1, lo2;
    logic signed [lgd_pkg::Q_W-1:0]     mul_a, mul_b;
    logic signed [lgd_pkg::ACC_W-1:0]   acc_sh;
    logic [lgd_pkg::SUM_W-1:0]          sum;
    logic                               term_busy;

    assign v1x   = r_cfg[lgd_pkg::REG_V1][31:0];
    assign v1y   = r_cfg[lgd_pkg::REG_V1][63:32];
    assign v2x   = r_cfg[lgd_pkg::REG_V2][31:0];
    assign v2y   = r_cfg[lgd_pkg::REG_V2][63:32];
    assign bx    = r_cfg[lgd_pkg::REG_BASIS][31:0];
    assign by    = r_cfg[lgd_pkg::REG_BASIS][63:32];
    assign cx    = r_cfg[lgd_pkg::REG_CENTER][31:0];
    assign cy    = r_cfg[lgd_pkg::REG_CENTER][63:32];
    assign ct    = r_cfg[lgd_pkg::REG_ROT][31:0];
    assign st    = r_cfg[lgd_pkg::REG_ROT][63:32];
    assign i11   = r_cfg[lgd_pkg::REG_INV1][31:0];
    assign i12   = r_cfg[lgd_pkg::REG_INV1][63:32];
    assign i21   = r_cfg[lgd_pkg::REG_INV2][31:0];
    assign i22   = r_cfg[lgd_pkg::REG_INV2][63:32];
    assign alpha = r_cfg[lgd_pkg::REG_ALPHA][31:0];
    assign anorm = r_cfg[lgd_pkg::REG_ALPHA][63:32];

    assign lo1 = {{16{r_c1[31]}}, r_c1[31:16]} - lgd_pkg::Q_W'(lgd_pkg::WINDOW_RADIUS);
    assign lo2 = {{16{r_c2[31]}}, r_c2[31:16]} - lgd_pkg::Q_W'(lgd_pkg::WINDOW_RADIUS);
    assign acc_sh = r_acc >>> 16;

    assign o_sts.term_busy = term_busy;
    assign o_sts.out_busy  = r_out_valid && !i_ready;
    assign o_sts.row_count = lgd_pkg::CNT_W'(2 * lgd_pkg::WINDOW_RADIUS + 1)
                             + lgd_pkg::CNT_W'(r_c1[15:0] != 16'd0);
    assign o_sts.col_count = lgd_pkg::CNT_W'(2 * lgd_pkg::WINDOW_RADIUS + 1)
                             + lgd_pkg::CNT_W'(r_c2[15:0] != 16'd0);

    assign o_valid   = r_out_valid;
    assign o_density = r_density;

    lgd_term u_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (i_cmd.clear_sum),
        .i_issue (i_cmd.issue),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .i_xa    (r_xa),
        .i_ya    (r_ya),
        .i_offx  (i_cmd.atom ? bx : '0),
        .i_offy  (i_cmd.atom ? by : '0),
        .i_alpha (alpha),
        .o_sum   (sum),
        .o_busy  (term_busy)
    );

    always_comb begin
        case (i_cmd.step)
            lgd_pkg::ST_R1: begin mul_a = r_rx; mul_b = ct;  end
            lgd_pkg::ST_R2: begin mul_a = r_ry; mul_b = st;  end
            lgd_pkg::ST_R3: begin mul_a = r_rx; mul_b = st;  end
            lgd_pkg::ST_R4: begin mul_a = r_ry; mul_b = ct;  end
            lgd_pkg::ST_I1: begin mul_a = i11;  mul_b = r_dx; end
            lgd_pkg::ST_I2: begin mul_a = i12;  mul_b = r_dy; end
            lgd_pkg::ST_I3: begin mul_a = i21;  mul_b = r_dx; end
            lgd_pkg::ST_I4: begin mul_a = i22;  mul_b = r_dy; end
            lgd_pkg::ST_P1: begin mul_a = lo1;  mul_b = v1x; end
            lgd_pkg::ST_P2: begin mul_a = lo2;  mul_b = v2x; end
            lgd_pkg::ST_P3: begin mul_a = lo1;  mul_b = v1y; end
            lgd_pkg::ST_P4: begin mul_a = lo2;  mul_b = v2y; end
            default:        begin mul_a = '0;   mul_b = '0;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < lgd_pkg::NUM_REGS; k++) begin
                r_cfg[k] <= '0;
            end
            r_cfg[lgd_pkg::REG_ROT] <= lgd_pkg::ROT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg[i_cfg_addr] <= i_cfg_data;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_point_x;
            r_py <= i_point_y;
        end
        if (i_cmd.setup) begin
            r_prod <= 64'(mul_a) * 64'(mul_b);
            case (i_cmd.step)
                lgd_pkg::ST_DIFF: begin
                    r_rx <= lgd_pkg::sat32(lgd_pkg::ACC_W'(r_px) - lgd_pkg::ACC_W'(cx));
                    r_ry <= lgd_pkg::sat32(lgd_pkg::ACC_W'(r_py) - lgd_pkg::ACC_W'(cy));
                end
                lgd_pkg::ST_R2, lgd_pkg::ST_I2, lgd_pkg::ST_P2, lgd_pkg::ST_R5,
                lgd_pkg::ST_I5, lgd_pkg::ST_P5, lgd_pkg::ST_I3, lgd_pkg::ST_P3: begin
                    if (i_cmd.step == lgd_pkg::ST_R2 || i_cmd.step == lgd_pkg::ST_I2
                        || i_cmd.step == lgd_pkg::ST_P2) begin
                        r_acc <= lgd_pkg::ACC_W'(r_prod);
                    end else begin
                        r_acc <= r_acc + lgd_pkg::ACC_W'(r_prod);
                    end
                end
                lgd_pkg::ST_R3: begin
                    r_acc <= r_acc - lgd_pkg::ACC_W'(r_prod);
                end
                lgd_pkg::ST_R4: begin
                    r_dx  <= lgd_pkg::sat32(acc_sh + lgd_pkg::ACC_W'(cx));
                    r_acc <= lgd_pkg::ACC_W'(r_prod);
                end
                lgd_pkg::ST_DY: begin
                    r_dy <= lgd_pkg::sat32(acc_sh + lgd_pkg::ACC_W'(cy));
                end
                lgd_pkg::ST_I4: begin
                    r_c1  <= lgd_pkg::sat32(acc_sh);
                    r_acc <= lgd_pkg::ACC_W'(r_prod);
                end
                lgd_pkg::ST_C2: begin
                    r_c2 <= lgd_pkg::sat32(acc_sh);
                end
                lgd_pkg::ST_P4: begin
                    r_xa   <= lgd_pkg::POS_W'(r_acc);
                    r_xrow <= lgd_pkg::POS_W'(r_acc);
                    r_acc  <= lgd_pkg::ACC_W'(r_prod);
                end
                lgd_pkg::ST_LAST: begin
                    r_ya   <= lgd_pkg::POS_W'(r_acc);
                    r_yrow <= lgd_pkg::POS_W'(r_acc);
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.step_col) begin
            r_xa <= r_xa + lgd_pkg::POS_W'(v2x);
            r_ya <= r_ya + lgd_pkg::POS_W'(v2y);
        end else if (i_cmd.step_row) begin
            r_xrow <= r_xrow + lgd_pkg::POS_W'(v1x);
            r_yrow <= r_yrow + lgd_pkg::POS_W'(v1y);
            r_xa   <= r_xrow + lgd_pkg::POS_W'(v1x);
            r_ya   <= r_yrow + lgd_pkg::POS_W'(v1y);
        end
        if (i_cmd.scale) begin
            r_dprod <= DP_W'(sum) * DP_W'(anorm);
        end
        if (i_cmd.out_load) begin
            r_density <= (|r_dprod[DP_W-1:48]) ? '1 : r_dprod[47:16];
        end
    end

endmodule

/* rtl/lattice_gaussian_density_top.sv */
// Sequence: the setup steps, then 2*R1*R2 Gaussian terms (R1, R2 = 11 or 12 cells, so
// 242 to 288 terms), then pipeline drain, scaling and output load before o_valid.
// Throughput: one point at a time, a new point is taken only while idle, and the finish
// waits while an earlier result is still held; one Gaussian term issued per cycle.
// Reset: synchronous, active low; registers take their reset values, nothing to clear.
`timescale 1ns / 1ps
module lattice_gaussian_density_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lgd_pkg::ADDR_W-1:0]      i_cfg_addr,
    input  logic [lgd_pkg::REG_W-1:0]       i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [lgd_pkg::Q_W-1:0]  i_point_x,
    input  logic signed [lgd_pkg::Q_W-1:0]  i_point_y,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [lgd_pkg::Q_W-1:0]         o_density
);

    lgd_pkg::t_cmd cmd;
    lgd_pkg::t_sts sts;

    lgd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    lgd_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_point_x  (i_point_x),
        .i_point_y  (i_point_y),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_density  (o_density),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !sts.term_busy)
        else $error("term pipeline busy while idle");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !sts.out_busy)
        else $error("output register overwritten");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second transfer taken during setup");

    a_issue_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.issue |-> !cmd.setup && !cmd.out_load)
        else $error("term issued outside cell sweep");

endmodule
